// File: src/gdfo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdfo_pkg
// Shared constants, types and helpers of the depth-first order unit.
// ----------------------------------------------------------------------------
package gdfo_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int ROW_W        = 32;
  localparam int CAP_VERTICES = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
  localparam int CNT_W        = 6;
  localparam int IDX_W        = 5;
  localparam int CFG_RESET    = 32;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Handover from the row loader to the walk sequencer.
  typedef struct packed {
    logic start;
    row_t mask;
  } walk_ctrl_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic idx_t lowest_index(input row_t v);
    row_t iso;
    idx_t idx;
    iso = v & (~v + row_t'(1));
    idx = '0;
    for (int i = 0; i < ROW_W; i++) begin
      if (iso[i]) begin
        idx = idx | idx_t'(i);
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: src/gdfo_row_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdfo_row_if
// Valid/ready channel carrying one adjacency row per word.
// ----------------------------------------------------------------------------
interface gdfo_row_if;
  logic               valid;
  logic               ready;
  gdfo_pkg::row_t     row_bits;

  modport source (output valid, output row_bits, input ready);
  modport sink   (input valid, input row_bits, output ready);
endinterface
`default_nettype wire

// File: src/gdfo_vtx_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdfo_vtx_if
// Valid/ready channel carrying one visited vertex number per word.
// ----------------------------------------------------------------------------
interface gdfo_vtx_if;
  logic               valid;
  logic               ready;
  gdfo_pkg::cnt_t     vertex_number;
  logic               last_of_run;

  modport source (output valid, output vertex_number, output last_of_run, input ready);
  modport sink   (input valid, input vertex_number, input last_of_run, output ready);
endinterface
`default_nettype wire

// File: src/gdfo_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdfo_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gdfo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: src/gdfo_loader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdfo_loader
// Holds the vertex count register, writes incoming rows into the adjacency
// memory and starts a walk when the matrix is complete.
// ----------------------------------------------------------------------------
module gdfo_loader (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire gdfo_pkg::cnt_t       cfg_wr_data,
  input  wire logic                 in_valid,
  input  wire gdfo_pkg::row_t       in_row_bits,
  output logic                      in_ready,
  input  wire logic                 walk_idle,
  output logic                      adj_wr_en,
  output gdfo_pkg::idx_t            adj_wr_addr,
  output gdfo_pkg::row_t            adj_wr_data,
  output gdfo_pkg::walk_ctrl_t      ctrl
);
  import gdfo_pkg::*;

  cnt_t cfg_count_r, cfg_count_nxt;
  cnt_t rows_loaded_r, rows_loaded_nxt;
  cnt_t eff_count;
  logic accept;
  logic complete;

  always_comb begin
    eff_count = cfg_count_r;
    if (eff_count == '0) begin
      eff_count = cnt_t'(1);
    end
    if (eff_count > cnt_t'(CAP_VERTICES)) begin
      eff_count = cnt_t'(CAP_VERTICES);
    end
  end

  assign in_ready = walk_idle;
  assign accept   = in_valid && in_ready;
  // The row just taken completes the matrix once the count reaches the limit.
  assign complete = ({1'b0, rows_loaded_r} + 7'd1) >= {1'b0, eff_count};

  always_comb begin
    cfg_count_nxt   = cfg_wr_en ? cfg_wr_data : cfg_count_r;
    rows_loaded_nxt = rows_loaded_r;
    if (accept) begin
      rows_loaded_nxt = complete ? '0 : rows_loaded_r + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r   <= cnt_t'(CFG_RESET);
      rows_loaded_r <= '0;
    end else begin
      cfg_count_r   <= cfg_count_nxt;
      rows_loaded_r <= rows_loaded_nxt;
    end
  end

  assign adj_wr_en   = accept;
  assign adj_wr_addr = rows_loaded_r[IDX_W-1:0];
  assign adj_wr_data = in_row_bits;

  assign ctrl.start = accept && complete;
  assign ctrl.mask  = (eff_count >= cnt_t'(ROW_W)) ? '1
                    : ((row_t'(1) << eff_count) - row_t'(1));

endmodule
`default_nettype wire

// File: src/gdfo_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdfo_walker
// Depth-first walk sequencer: visited bitmap, stack pointer and output word
// register, working on the adjacency and stack memories.
// ----------------------------------------------------------------------------
module gdfo_walker (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire gdfo_pkg::walk_ctrl_t ctrl,
  output logic                      walk_idle,
  output gdfo_pkg::idx_t            adj_rd_addr,
  input  wire gdfo_pkg::row_t       adj_rd_data,
  output logic                      stk_wr_en,
  output gdfo_pkg::idx_t            stk_wr_addr,
  output gdfo_pkg::idx_t            stk_wr_data,
  output gdfo_pkg::idx_t            stk_rd_addr,
  input  wire gdfo_pkg::idx_t       stk_rd_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output gdfo_pkg::cnt_t            out_vertex_number,
  output logic                      out_last_of_run
);
  import gdfo_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_PWAIT = 3'd4;
  localparam logic [2:0] S_PTOP  = 3'd5;

  logic [2:0] state_r, state_nxt;
  row_t       visited_r, visited_nxt;
  cnt_t       depth_r, depth_nxt;
  idx_t       top_r, top_nxt;
  logic       out_valid_r, out_valid_nxt;
  cnt_t       out_vtx_r, out_vtx_nxt;
  logic       out_last_r, out_last_nxt;

  row_t cand;
  logic any;
  idx_t pick;
  row_t pick_bit;
  logic out_free;
  logic emit;

  // At a fresh start every lower vertex is already visited, so the lowest
  // unvisited vertex is the next root.
  assign cand     = ((state_r == S_START) ? ctrl.mask : (adj_rd_data & ctrl.mask))
                    & ~visited_r;
  assign any      = |cand;
  assign pick     = lowest_index(cand);
  assign pick_bit = row_t'(1) << pick;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    visited_nxt = visited_r;
    depth_nxt   = depth_r;
    top_nxt     = top_r;
    emit        = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (ctrl.start) begin
          visited_nxt = '0;
          depth_nxt   = '0;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        if (!any) begin
          state_nxt = S_LOAD;
        end else if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (any) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_READ;
          end
        end else begin
          depth_nxt = depth_r - cnt_t'(1);
          state_nxt = (depth_r == cnt_t'(1)) ? S_START : S_PWAIT;
        end
      end
      S_PWAIT: begin
        state_nxt = S_PTOP;
      end
      S_PTOP: begin
        top_nxt   = stk_rd_data;
        state_nxt = S_EVAL;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    if (emit) begin
      visited_nxt = visited_r | pick_bit;
      top_nxt     = pick;
      if (depth_r < cnt_t'(ROW_W)) begin
        depth_nxt = depth_r + cnt_t'(1);
      end
    end
  end

  assign stk_wr_en   = emit && (depth_r < cnt_t'(ROW_W));
  assign stk_wr_addr = depth_r[IDX_W-1:0];
  assign stk_wr_data = pick;
  assign stk_rd_addr = depth_r[IDX_W-1:0] - idx_t'(1);
  // The popped top goes straight to the adjacency read so EVAL follows at once.
  assign adj_rd_addr = (state_r == S_PTOP) ? stk_rd_data : top_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_vtx_nxt   = out_vtx_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_vtx_nxt   = {1'b0, pick} + cnt_t'(1);
      out_last_nxt  = ((visited_r | pick_bit) == ctrl.mask);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      visited_r   <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    out_vtx_r  <= out_vtx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign walk_idle         = (state_r == S_LOAD);
  assign out_valid         = out_valid_r;
  assign out_vertex_number = out_vtx_r;
  assign out_last_of_run   = out_last_r;

  a_idle_stack_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> (depth_r == '0))
    else $error("stack not empty while loading rows");

  a_eval_has_top: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (depth_r != '0))
    else $error("neighbour scan with an empty stack");

  a_emit_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !visited_r[pick])
    else $error("vertex emitted twice in one walk");

  a_emit_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (depth_r == ($past(depth_r) + cnt_t'(1))) && (top_r == $past(pick)))
    else $error("visit did not push its vertex");

endmodule
`default_nettype wire

// File: src/graph_depth_first_order_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// graph_depth_first_order_unit
// Depth-first visiting order of a graph loaded as an adjacency matrix.
// ----------------------------------------------------------------------------
// Usage: rows arrive on in_ch, one word per row, row i first. Bit j of a row
// is an edge to vertex j+1. cfg_wr_data sets the vertex count (0 acts as 1,
// anything above 32 as 32); write it only while the block is idle.
// Rows are taken one per cycle. The row that completes the matrix starts a
// walk, and in_ch.ready stays low until the walk is over. The walk emits
// every vertex once on out_ch, numbered from 1, with last_of_run set on the
// final word. A visit passes through an adjacency read, then a neighbour
// scan, and a backtrack through the scan, a stack memory read, then a new
// adjacency read; the last backtrack of each tree goes straight to the next
// root. Both memories have registered read ports. When out_ch is stalled
// the walk holds at its next visit; one finished word waits in the output
// register. Reset empties the stack, clears the row count and sets the
// vertex count to 32; the memories need no clearing, as every row is
// written before a walk reads it.
// ----------------------------------------------------------------------------
module graph_depth_first_order_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  gdfo_row_if.sink            in_ch,
  gdfo_vtx_if.source          out_ch,
  input  wire logic           cfg_wr_en,
  input  wire gdfo_pkg::cnt_t cfg_wr_data
);
  import gdfo_pkg::*;

  walk_ctrl_t ctrl;
  logic       walk_idle;
  logic       adj_wr_en;
  idx_t       adj_wr_addr;
  row_t       adj_wr_data;
  idx_t       adj_rd_addr;
  row_t       adj_rd_data;
  logic       stk_wr_en;
  idx_t       stk_wr_addr;
  idx_t       stk_wr_data;
  idx_t       stk_rd_addr;
  idx_t       stk_rd_data;

  gdfo_loader u_loader (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_ch.valid),
    .in_row_bits (in_ch.row_bits),
    .in_ready    (in_ch.ready),
    .walk_idle   (walk_idle),
    .adj_wr_en   (adj_wr_en),
    .adj_wr_addr (adj_wr_addr),
    .adj_wr_data (adj_wr_data),
    .ctrl        (ctrl)
  );

  gdfo_ram #(.WIDTH(ROW_W), .DEPTH(ROW_W)) u_adj_ram (
    .clk     (clk),
    .wr_en   (adj_wr_en),
    .wr_addr (adj_wr_addr),
    .wr_data (adj_wr_data),
    .rd_addr (adj_rd_addr),
    .rd_data (adj_rd_data)
  );

  gdfo_ram #(.WIDTH(IDX_W), .DEPTH(ROW_W)) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  gdfo_walker u_walker (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .walk_idle         (walk_idle),
    .adj_rd_addr       (adj_rd_addr),
    .adj_rd_data       (adj_rd_data),
    .stk_wr_en         (stk_wr_en),
    .stk_wr_addr       (stk_wr_addr),
    .stk_wr_data       (stk_wr_data),
    .stk_rd_addr       (stk_rd_addr),
    .stk_rd_data       (stk_rd_data),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_vertex_number (out_ch.vertex_number),
    .out_last_of_run   (out_ch.last_of_run)
  );

endmodule
`default_nettype wire
